// ----- src/pfs_pkg.sv -----
// Shared types and constants for the PWM fault supervisor.
// No dependencies; every other file of the block imports this package.
package pfs_pkg;

  // Fixed field widths of the command and result items.
  localparam int FUNC_W = 4;
  localparam int CHAN_W = 3;
  localparam int MASK_W = 5;

  // Command codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FN_INIT     = 4'd0,
    FN_START    = 4'd1,
    FN_STOP     = 4'd2,
    FN_STOP_ALL = 4'd3,
    FN_CLR_OCP  = 4'd4,
    FN_CLR_OVP  = 4'd5,
    FN_CLR_ALL  = 4'd6,
    FN_OCP_EVT  = 4'd7,
    FN_OVP_EVT  = 4'd8,
    FN_QUERY    = 4'd9
  } func_t;

  // Per-channel operating mode.
  typedef enum logic [1:0] {
    MODE_UNINIT  = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_RUNNING = 2'd2,
    MODE_FAULTED = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RESP
  } ctrl_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming item and its fault samples
    logic step1;  // apply the command rules
    logic step2;  // per-channel overcurrent clears of a clear-all command
    logic resp;   // load the result register
  } dp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic clr_all;  // the captured command is clear all
  } dp_status_t;

endpackage

// ----- src/pfs_ctrl.sv -----
// Sequencer of the PWM fault supervisor: walks each item through its steps.
// Depends on pfs_pkg; drives the datapath through dp_cmd_t.
module pfs_ctrl
  import pfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.step1  = 1'b1;
        state_next = sts.clr_all ? ST_SWEEP : ST_RESP;
      end
      ST_SWEEP: begin
        cmd.step2  = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        // Wait until the result register is free or is being emptied.
        if (!out_valid || !out_stall) begin
          cmd.resp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.resp | (out_valid & out_stall);
  end

endmodule

// ----- src/pfs_datapath.sv -----
// Datapath of the PWM fault supervisor: channel state, latches and result register.
// Depends on pfs_pkg; sequenced by pfs_ctrl through dp_cmd_t.
module pfs_datapath
  import pfs_pkg::*;
#(
  parameter int NUM_CHANNELS = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          sts,
  input  logic [FUNC_W-1:0]   func,
  input  logic [CHAN_W-1:0]   channel,
  input  logic                ovp_active,
  input  logic                ovp_pending,
  input  logic [MASK_W-1:0]   ocp_active_mask,
  input  logic [MASK_W-1:0]   ocp_pending_mask,
  output logic                ok,
  output logic [1:0]          chan_state,
  output logic [MASK_W-1:0]   enable_mask,
  output logic [MASK_W-1:0]   ocp_latch_mask,
  output logic                ovp_latch,
  output logic [MASK_W-1:0]   clear_ocp_pending,
  output logic                clear_ovp_pending
);

  localparam int N  = NUM_CHANNELS;
  localparam int EW = (N > MASK_W) ? N : MASK_W;

  // Supervisor state.
  mode_t        mode      [N];
  mode_t        mode_next [N];
  logic [N-1:0] lat, lat_next;
  logic         ovl, ovl_next;
  logic [N-1:0] en, en_next;

  // Captured item and work registers of the current command.
  logic [FUNC_W-1:0] smp_func;
  logic [CHAN_W-1:0] smp_chan;
  logic              smp_oa;
  logic              smp_op;
  logic [MASK_W-1:0] smp_act;
  logic [MASK_W-1:0] smp_pend;
  logic              wok, wok_next;
  logic [N-1:0]      pls_ocp, pls_ocp_next;
  logic              pls_ovp, pls_ovp_next;

  // Derived per-channel signals.
  logic [EW-1:0] act_w, pend_w, en_w, lat_w, pls_w;
  logic [N-1:0]  act, pend, sel, seen_oc;
  logic          chan_ok;
  logic          ov_seen;
  mode_t         cur_mode;
  mode_t         cl_mode [N];
  logic [N-1:0]  cl_lat, cl_en, cl_pls, cl_r;
  logic          any_after;

  // Samples widened to the channel count; missing channels read as zero.
  assign act_w  = EW'(smp_act);
  assign pend_w = EW'(smp_pend);
  assign act    = act_w[N-1:0];
  assign pend   = pend_w[N-1:0];

  assign chan_ok     = 32'(smp_chan) < N;
  assign ov_seen     = ovl | smp_oa | smp_op;
  assign seen_oc     = lat | act | pend;
  assign sts.clr_all = (smp_func == FN_CLR_ALL);

  // Channel select and mode of the addressed channel.
  always_comb begin
    cur_mode = MODE_UNINIT;
    for (int i = 0; i < N; i++) begin
      sel[i] = chan_ok && (32'(smp_chan) == i);
      if (sel[i]) begin
        cur_mode = mode[i];
      end
    end
  end

  // Overcurrent clear of every channel on its own, with no overvoltage present.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cl_mode[i] = mode[i];
      cl_lat[i]  = lat[i];
      cl_en[i]   = en[i];
      cl_pls[i]  = 1'b0;
      cl_r[i]    = 1'b0;
      if (mode[i] != MODE_UNINIT) begin
        if (!seen_oc[i]) begin
          cl_r[i] = 1'b1;
        end else begin
          cl_en[i] = 1'b0;
          if (act[i]) begin
            cl_lat[i]  = 1'b1;
            cl_mode[i] = MODE_FAULTED;
          end else begin
            cl_pls[i] = 1'b1;
            if (pend[i]) begin
              cl_lat[i]  = 1'b1;
              cl_mode[i] = MODE_FAULTED;
            end else begin
              cl_lat[i]  = 1'b0;
              cl_mode[i] = MODE_STOPPED;
              cl_r[i]    = 1'b1;
            end
          end
        end
      end
    end
    any_after = |(cl_lat | act | pend);
  end

  // Command rules.
  always_comb begin
    mode_next    = mode;
    lat_next     = lat;
    ovl_next     = ovl;
    en_next      = en;
    wok_next     = wok;
    pls_ocp_next = pls_ocp;
    pls_ovp_next = pls_ovp;
    if (cmd.load) begin
      wok_next     = 1'b0;
      pls_ocp_next = '0;
      pls_ovp_next = 1'b0;
    end else if (cmd.step1) begin
      case (smp_func)
        FN_INIT: begin
          if (chan_ok) begin
            for (int i = 0; i < N; i++) begin
              if (sel[i]) begin
                en_next[i]   = 1'b0;
                mode_next[i] = MODE_STOPPED;
              end
            end
            if (ov_seen) begin
              en_next  = '0;
              ovl_next = 1'b1;
              for (int i = 0; i < N; i++) begin
                if (mode_next[i] != MODE_UNINIT) mode_next[i] = MODE_FAULTED;
              end
            end
            for (int i = 0; i < N; i++) begin
              if (sel[i] && seen_oc[i]) begin
                en_next[i]   = 1'b0;
                lat_next[i]  = 1'b1;
                mode_next[i] = MODE_FAULTED;
              end
            end
            wok_next = 1'b1;
          end
        end
        FN_START: begin
          if (chan_ok && cur_mode == MODE_STOPPED) begin
            if (ov_seen) begin
              en_next  = '0;
              ovl_next = 1'b1;
              for (int i = 0; i < N; i++) begin
                if (mode[i] != MODE_UNINIT) mode_next[i] = MODE_FAULTED;
              end
            end
            for (int i = 0; i < N; i++) begin
              if (sel[i]) begin
                if (seen_oc[i]) begin
                  en_next[i]   = 1'b0;
                  lat_next[i]  = 1'b1;
                  mode_next[i] = MODE_FAULTED;
                end else if (!ov_seen) begin
                  en_next[i]   = 1'b1;
                  mode_next[i] = MODE_RUNNING;
                  wok_next     = 1'b1;
                end
              end
            end
          end
        end
        FN_STOP: begin
          if (chan_ok) begin
            for (int i = 0; i < N; i++) begin
              if (sel[i]) begin
                en_next[i] = 1'b0;
                if (mode[i] == MODE_RUNNING) mode_next[i] = MODE_STOPPED;
              end
            end
            wok_next = 1'b1;
          end
        end
        FN_STOP_ALL: begin
          en_next = '0;
          for (int i = 0; i < N; i++) begin
            if (mode[i] == MODE_RUNNING) mode_next[i] = MODE_STOPPED;
          end
          wok_next = 1'b1;
        end
        FN_CLR_OCP: begin
          if (chan_ok) begin
            if (cur_mode == MODE_UNINIT) begin
              wok_next = 1'b0;
            end else if (smp_oa || smp_op) begin
              // A fresh overvoltage blocks the clear and trips the whole bridge.
              en_next  = '0;
              ovl_next = 1'b1;
              for (int i = 0; i < N; i++) begin
                if (mode[i] != MODE_UNINIT) mode_next[i] = MODE_FAULTED;
              end
            end else if (!ovl) begin
              for (int i = 0; i < N; i++) begin
                if (sel[i]) begin
                  mode_next[i]    = cl_mode[i];
                  lat_next[i]     = cl_lat[i];
                  en_next[i]      = cl_en[i];
                  pls_ocp_next[i] = cl_pls[i];
                  wok_next        = cl_r[i];
                end
              end
            end
          end
        end
        FN_CLR_OVP, FN_CLR_ALL: begin
          // Clear all first halts every channel.
          if (smp_func == FN_CLR_ALL) begin
            en_next = '0;
            for (int i = 0; i < N; i++) begin
              if (mode[i] == MODE_RUNNING) mode_next[i] = MODE_STOPPED;
            end
          end
          if (smp_oa) begin
            en_next  = '0;
            ovl_next = 1'b1;
            for (int i = 0; i < N; i++) begin
              if (mode_next[i] != MODE_UNINIT) mode_next[i] = MODE_FAULTED;
            end
            wok_next = 1'b0;
          end else if (!(ovl || smp_op)) begin
            wok_next = 1'b1;
          end else begin
            en_next      = '0;
            pls_ovp_next = 1'b1;
            if (smp_op) begin
              ovl_next = 1'b1;
              for (int i = 0; i < N; i++) begin
                if (mode_next[i] != MODE_UNINIT) mode_next[i] = MODE_FAULTED;
              end
              wok_next = 1'b0;
            end else begin
              // Overvoltage gone: channels drop back to stopped unless overcurrent remains.
              ovl_next = 1'b0;
              for (int i = 0; i < N; i++) begin
                if (mode_next[i] != MODE_UNINIT) begin
                  if (seen_oc[i]) begin
                    lat_next[i]  = 1'b1;
                    mode_next[i] = MODE_FAULTED;
                  end else begin
                    mode_next[i] = MODE_STOPPED;
                  end
                end
              end
              wok_next = 1'b1;
            end
          end
        end
        FN_OCP_EVT: begin
          if (chan_ok) begin
            for (int i = 0; i < N; i++) begin
              if (sel[i]) begin
                en_next[i]  = 1'b0;
                lat_next[i] = 1'b1;
                if (mode[i] != MODE_UNINIT) mode_next[i] = MODE_FAULTED;
              end
            end
            wok_next = 1'b1;
          end
        end
        FN_OVP_EVT: begin
          en_next  = '0;
          ovl_next = 1'b1;
          for (int i = 0; i < N; i++) begin
            if (mode[i] != MODE_UNINIT) mode_next[i] = MODE_FAULTED;
          end
          wok_next = 1'b1;
        end
        FN_QUERY: begin
          wok_next = ov_seen | (|seen_oc);
        end
        default: begin
          wok_next = 1'b0;
        end
      endcase
    end else if (cmd.step2) begin
      // Clear all: overcurrent clear of every channel, then a final fault check.
      if (wok) begin
        mode_next    = cl_mode;
        lat_next     = cl_lat;
        en_next      = cl_en;
        pls_ocp_next = pls_ocp | cl_pls;
        wok_next     = (&cl_r) & ~any_after;
      end
    end
  end

  // Supervisor state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        mode[i] <= MODE_UNINIT;
      end
      lat <= '0;
      ovl <= 1'b0;
      en  <= '0;
    end else begin
      mode <= mode_next;
      lat  <= lat_next;
      ovl  <= ovl_next;
      en   <= en_next;
    end
  end

  // Captured item and work registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_func <= func;
      smp_chan <= channel;
      smp_oa   <= ovp_active;
      smp_op   <= ovp_pending;
      smp_act  <= ocp_active_mask;
      smp_pend <= ocp_pending_mask;
    end
    wok     <= wok_next;
    pls_ocp <= pls_ocp_next;
    pls_ovp <= pls_ovp_next;
  end

  assign en_w  = EW'(en);
  assign lat_w = EW'(lat);
  assign pls_w = EW'(pls_ocp);

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      ok                <= wok;
      chan_state        <= cur_mode;
      enable_mask       <= en_w[MASK_W-1:0];
      ocp_latch_mask    <= lat_w[MASK_W-1:0];
      ovp_latch         <= ovl;
      clear_ocp_pending <= pls_w[MASK_W-1:0];
      clear_ovp_pending <= pls_ovp;
    end
  end

endmodule

// ----- src/pwm_fault_supervisor.sv -----
// Top level of the PWM fault supervisor: sequencer plus datapath.
// Depends on pfs_pkg, pfs_ctrl and pfs_datapath.
//
// Supervises up to NUM_CHANNELS half-bridge PWM channels (mode, overcurrent
// latch and output enable per channel) and one shared overvoltage latch.
// Each command item carries the live fault levels and pending flags; the
// block samples them once on acceptance, applies the command, and returns
// one result item with the success flag, the addressed channel's mode, the
// enable and latch masks, and clear pulses for the pending flags. The
// sequencer's steps are execute, one extra sweep of the per-channel clears
// for clear all, then the result load. The next command is accepted in the
// cycle after the result load. One command is worked on at a time; the next
// one is accepted while the previous result still waits in the output
// register, and its result load waits until that register is free.
// Channels at index 5 and above are kept internally but read zero levels
// and do not appear in the result masks.
module pwm_fault_supervisor
  import pfs_pkg::*;
#(
  parameter int NUM_CHANNELS = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [CHAN_W-1:0] channel,
  input  logic              ovp_active,
  input  logic              ovp_pending,
  input  logic [MASK_W-1:0] ocp_active_mask,
  input  logic [MASK_W-1:0] ocp_pending_mask,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [1:0]        chan_state,
  output logic [MASK_W-1:0] enable_mask,
  output logic [MASK_W-1:0] ocp_latch_mask,
  output logic              ovp_latch,
  output logic [MASK_W-1:0] clear_ocp_pending,
  output logic              clear_ovp_pending
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencer.
  pfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Channel state and result datapath.
  pfs_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .func              (func),
    .channel           (channel),
    .ovp_active        (ovp_active),
    .ovp_pending       (ovp_pending),
    .ocp_active_mask   (ocp_active_mask),
    .ocp_pending_mask  (ocp_pending_mask),
    .ok                (ok),
    .chan_state        (chan_state),
    .enable_mask       (enable_mask),
    .ocp_latch_mask    (ocp_latch_mask),
    .ovp_latch         (ovp_latch),
    .clear_ocp_pending (clear_ocp_pending),
    .clear_ovp_pending (clear_ovp_pending)
  );

endmodule

// ----- src/pfs_checker.sv -----
// Port-level checks for the PWM fault supervisor, bound to its top level.
// Depends on pfs_pkg and pwm_fault_supervisor.
module pfs_checker
  import pfs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              ok,
  input logic [1:0]        chan_state,
  input logic [MASK_W-1:0] enable_mask,
  input logic [MASK_W-1:0] ocp_latch_mask,
  input logic              ovp_latch
);

  // The block works on one item at a time: it is busy right after accepting.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("pfs: item accepted while a command was still in progress");

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(ok) && $stable(chan_state)
      && $stable(enable_mask) && $stable(ocp_latch_mask)))
    else $error("pfs: stalled result changed");

  // No output may be enabled while overvoltage is latched.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ovp_latch && (|enable_mask)))
    else $error("pfs: output enabled with overvoltage latched");

  // A channel with a latched overcurrent never has its output enabled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((enable_mask & ocp_latch_mask) == '0))
    else $error("pfs: output enabled on a channel with overcurrent latched");

endmodule

bind pwm_fault_supervisor pfs_checker u_pfs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .ok             (ok),
  .chan_state     (chan_state),
  .enable_mask    (enable_mask),
  .ocp_latch_mask (ocp_latch_mask),
  .ovp_latch      (ovp_latch)
);

// ----- tb/tb_pwm_fault_supervisor.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the PWM fault supervisor top level.
// Depends on pfs_pkg and pwm_fault_supervisor; it needs no files or arguments.
// Command items go through a driver queue and are predicted on acceptance.
module tb_pwm_fault_supervisor;
  import pfs_pkg::*;

  localparam int NCH = 5;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL = 200;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = FUNC_W'(FN_QUERY + 1);
  localparam logic [FUNC_W-1:0] FN_LAST_UNUSED = {FUNC_W{1'b1}};
  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};
  localparam logic [MASK_W-1:0] ALL_CH = {MASK_W{1'b1}};
  localparam logic [MASK_W-1:0] NO_CH = '0;

  // One command item as it appears on the input ports.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAN_W-1:0] chan;
    logic              ovp_act;
    logic              ovp_pend;
    logic [MASK_W-1:0] ocp_act;
    logic [MASK_W-1:0] ocp_pend;
  } command_t;

  // One result item as it appears on the output ports.
  typedef struct packed {
    logic              ok;
    logic [1:0]        state;
    logic [MASK_W-1:0] enables;
    logic [MASK_W-1:0] ocp_latches;
    logic              ovp_latch;
    logic [MASK_W-1:0] ocp_clear;
    logic              ovp_clear;
  } status_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func = '0;
  logic [CHAN_W-1:0] channel = '0;
  logic              ovp_active = 1'b0;
  logic              ovp_pending = 1'b0;
  logic [MASK_W-1:0] ocp_active_mask = '0;
  logic [MASK_W-1:0] ocp_pending_mask = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              ok;
  logic [1:0]        chan_state;
  logic [MASK_W-1:0] enable_mask;
  logic [MASK_W-1:0] ocp_latch_mask;
  logic              ovp_latch;
  logic [MASK_W-1:0] clear_ocp_pending;
  logic              clear_ovp_pending;

  pwm_fault_supervisor #(.NUM_CHANNELS(NCH)) dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .channel           (channel),
    .ovp_active        (ovp_active),
    .ovp_pending       (ovp_pending),
    .ocp_active_mask   (ocp_active_mask),
    .ocp_pending_mask  (ocp_pending_mask),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .ok                (ok),
    .chan_state        (chan_state),
    .enable_mask       (enable_mask),
    .ocp_latch_mask    (ocp_latch_mask),
    .ovp_latch         (ovp_latch),
    .clear_ocp_pending (clear_ocp_pending),
    .clear_ovp_pending (clear_ovp_pending)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the supervisor state.
  mode_t             mode_q [NCH];
  logic [MASK_W-1:0] ocp_lat;
  logic              ovp_lat;
  logic [MASK_W-1:0] out_en;

  // Fault samples of the command being predicted, plus its clear pulses.
  logic              smp_ovp_act;
  logic              smp_ovp_pend;
  logic [MASK_W-1:0] smp_ocp_act;
  logic [MASK_W-1:0] smp_ocp_pend;
  logic [MASK_W-1:0] pulse_ocp;
  logic              pulse_ovp;

  command_t pending_cmds [$];
  status_t  status_due [$];
  command_t on_wire;
  int       n_total = 0;
  int       n_taken = 0;
  int       n_results = 0;
  int       n_errors = 0;
  int       send_gap = 0;
  int       rcv_gap = 0;
  logic     calm = 1'b0;
  logic     long_hold = 1'b0;

  function automatic logic ocp_fault_seen(int c);
    return ocp_lat[c] | smp_ocp_act[c] | smp_ocp_pend[c];
  endfunction

  function automatic logic ovp_fault_seen();
    return ovp_lat | smp_ovp_act | smp_ovp_pend;
  endfunction

  function automatic void latch_ocp(int c);
    out_en[c] = 1'b0;
    ocp_lat[c] = 1'b1;
    if (mode_q[c] != MODE_UNINIT) mode_q[c] = MODE_FAULTED;
  endfunction

  function automatic void latch_ovp();
    int i;
    out_en = '0;
    ovp_lat = 1'b1;
    for (i = 0; i < NCH; i++)
      if (mode_q[i] != MODE_UNINIT) mode_q[i] = MODE_FAULTED;
  endfunction

  // Latches whatever fault touches channel c; true if there was one.
  function automatic logic trip_if_faulted(int c);
    logic ov;
    logic oc;
    ov = ovp_fault_seen();
    oc = ocp_fault_seen(c);
    if (ov) latch_ovp();
    if (oc) latch_ocp(c);
    return ov | oc;
  endfunction

  function automatic void halt_channel(int c);
    out_en[c] = 1'b0;
    if (mode_q[c] == MODE_RUNNING) mode_q[c] = MODE_STOPPED;
  endfunction

  function automatic void halt_every_channel();
    int i;
    for (i = 0; i < NCH; i++) halt_channel(i);
  endfunction

  function automatic logic fault_present();
    int i;
    if (ovp_fault_seen()) return 1'b1;
    for (i = 0; i < NCH; i++)
      if (ocp_fault_seen(i)) return 1'b1;
    return 1'b0;
  endfunction

  // Overcurrent clear of one channel; overvoltage blocks it.
  function automatic logic try_clear_ocp(int c);
    if (mode_q[c] == MODE_UNINIT) return 1'b0;
    if (smp_ovp_act || smp_ovp_pend) begin
      latch_ovp();
      return 1'b0;
    end
    if (ovp_lat) return 1'b0;
    if (!ocp_fault_seen(c)) return 1'b1;
    out_en[c] = 1'b0;
    if (smp_ocp_act[c]) begin
      latch_ocp(c);
      return 1'b0;
    end
    pulse_ocp[c] = 1'b1;
    // The re-read after the pulse sees the same pending sample.
    if (smp_ocp_pend[c]) begin
      latch_ocp(c);
      return 1'b0;
    end
    ocp_lat[c] = 1'b0;
    mode_q[c] = MODE_STOPPED;
    return 1'b1;
  endfunction

  // Overvoltage clear; faulted channels recover unless overcurrent remains.
  function automatic logic try_clear_ovp();
    logic had;
    int i;
    had = ovp_lat | smp_ovp_pend;
    if (smp_ovp_act) begin
      latch_ovp();
      return 1'b0;
    end
    if (!had) return 1'b1;
    latch_ovp();
    pulse_ovp = 1'b1;
    if (smp_ovp_pend) return 1'b0;
    ovp_lat = 1'b0;
    for (i = 0; i < NCH; i++) begin
      if (mode_q[i] != MODE_UNINIT) begin
        if (ocp_fault_seen(i)) latch_ocp(i);
        else if (mode_q[i] == MODE_FAULTED) mode_q[i] = MODE_STOPPED;
      end
    end
    return 1'b1;
  endfunction

  // Applies one command to the shadow state and returns its result item.
  function automatic status_t apply_command(command_t cmd);
    status_t r;
    logic    hit;
    logic    good;
    int      c;
    int      i;
    c = int'(cmd.chan);
    hit = (c < NCH);
    good = 1'b0;
    smp_ovp_act = cmd.ovp_act;
    smp_ovp_pend = cmd.ovp_pend;
    smp_ocp_act = cmd.ocp_act;
    smp_ocp_pend = cmd.ocp_pend;
    pulse_ocp = '0;
    pulse_ovp = 1'b0;
    case (cmd.func)
      FN_INIT: if (hit) begin
        halt_channel(c);
        mode_q[c] = MODE_STOPPED;
        void'(trip_if_faulted(c));
        good = 1'b1;
      end
      FN_START: if (hit && mode_q[c] == MODE_STOPPED) begin
        if (!trip_if_faulted(c)) begin
          out_en[c] = 1'b1;
          mode_q[c] = MODE_RUNNING;
          good = 1'b1;
        end
      end
      FN_STOP: if (hit) begin
        halt_channel(c);
        good = 1'b1;
      end
      FN_STOP_ALL: begin
        halt_every_channel();
        good = 1'b1;
      end
      FN_CLR_OCP: if (hit) good = try_clear_ocp(c);
      FN_CLR_OVP: good = try_clear_ovp();
      FN_CLR_ALL: begin
        halt_every_channel();
        if (try_clear_ovp()) begin
          good = 1'b1;
          for (i = 0; i < NCH; i++)
            if (!try_clear_ocp(i)) good = 1'b0;
          if (good && fault_present()) good = 1'b0;
        end
      end
      FN_OCP_EVT: if (hit) begin
        latch_ocp(c);
        good = 1'b1;
      end
      FN_OVP_EVT: begin
        latch_ovp();
        good = 1'b1;
      end
      FN_QUERY: good = fault_present();
      default: good = 1'b0;
    endcase
    r.ok = good;
    if (hit) r.state = mode_q[c];
    else r.state = MODE_UNINIT;
    r.enables = out_en;
    r.ocp_latches = ocp_lat;
    r.ovp_latch = ovp_lat;
    r.ocp_clear = pulse_ocp;
    r.ovp_clear = pulse_ovp;
    return r;
  endfunction

  task automatic queue_command(input logic [FUNC_W-1:0] f, input int c,
                               input logic oa, input logic op,
                               input logic [MASK_W-1:0] ca, input logic [MASK_W-1:0] cp);
    command_t cmd;
    cmd.func = f;
    cmd.chan = CHAN_W'(c);
    cmd.ovp_act = oa;
    cmd.ovp_pend = op;
    cmd.ocp_act = ca;
    cmd.ocp_pend = cp;
    pending_cmds.push_back(cmd);
    n_total++;
  endtask

  // Random command: mostly clean fault samples so channels get to run.
  task automatic queue_random_command();
    command_t cmd;
    int       pick;
    int       kind;
    pick = $urandom_range(0, 99);
    if (pick < 16) cmd.func = FN_INIT;
    else if (pick < 36) cmd.func = FN_START;
    else if (pick < 46) cmd.func = FN_STOP;
    else if (pick < 50) cmd.func = FN_STOP_ALL;
    else if (pick < 62) cmd.func = FN_CLR_OCP;
    else if (pick < 70) cmd.func = FN_CLR_OVP;
    else if (pick < 78) cmd.func = FN_CLR_ALL;
    else if (pick < 85) cmd.func = FN_OCP_EVT;
    else if (pick < 88) cmd.func = FN_OVP_EVT;
    else if (pick < 97) cmd.func = FN_QUERY;
    else cmd.func = FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
    if ($urandom_range(0, 9) == 0) cmd.chan = CHAN_W'($urandom_range(NCH, CHAN_MAX));
    else cmd.chan = CHAN_W'($urandom_range(0, NCH - 1));
    cmd.ovp_act = 1'b0;
    cmd.ovp_pend = 1'b0;
    cmd.ocp_act = '0;
    cmd.ocp_pend = '0;
    kind = $urandom_range(0, 9);
    if (kind == 6) cmd.ocp_pend[$urandom_range(0, MASK_W - 1)] = 1'b1;
    else if (kind == 7) cmd.ocp_act[$urandom_range(0, MASK_W - 1)] = 1'b1;
    else if (kind == 8) begin
      cmd.ovp_pend = 1'($urandom_range(0, 1));
      cmd.ocp_pend = MASK_W'($urandom_range(0, ALL_CH));
    end else if (kind == 9) begin
      cmd.ovp_act = 1'($urandom_range(0, 1));
      cmd.ovp_pend = 1'($urandom_range(0, 1));
      cmd.ocp_act = MASK_W'($urandom_range(0, ALL_CH));
      cmd.ocp_pend = MASK_W'($urandom_range(0, ALL_CH));
    end
    queue_command(cmd.func, int'(cmd.chan), cmd.ovp_act, cmd.ovp_pend, cmd.ocp_act,
                  cmd.ocp_pend);
  endtask

  // Driver: predicts each accepted item, then offers the next one.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        status_due.push_back(apply_command(on_wire));
        n_taken++;
      end
      calm <= (pending_cmds.size() < CALM_TAIL);
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else begin
          on_wire = pending_cmds.pop_front();
          func <= on_wire.func;
          channel <= on_wire.chan;
          ovp_active <= on_wire.ovp_act;
          ovp_pending <= on_wire.ovp_pend;
          ocp_active_mask <= on_wire.ocp_act;
          ocp_pending_mask <= on_wire.ocp_pend;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output at random.
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.ok = ok;
        got.state = chan_state;
        got.enables = enable_mask;
        got.ocp_latches = ocp_latch_mask;
        got.ovp_latch = ovp_latch;
        got.ocp_clear = clear_ocp_pending;
        got.ovp_clear = clear_ovp_pending;
        if (status_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d arrived with no command outstanding", n_results);
        end else begin
          want = status_due.pop_front();
          if (got.ok !== want.ok || got.state !== want.state ||
              got.enables !== want.enables || got.ocp_latches !== want.ocp_latches ||
              got.ovp_latch !== want.ovp_latch || got.ocp_clear !== want.ocp_clear ||
              got.ovp_clear !== want.ovp_clear) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("ERROR: result %0d exp ok=%b st=%0d en=%b ocl=%b ovl=%b cocp=%b covp=%b",
                       n_results, want.ok, want.state, want.enables, want.ocp_latches,
                       want.ovp_latch, want.ocp_clear, want.ovp_clear);
              $display("       result %0d got ok=%b st=%0d en=%b ocl=%b ovl=%b cocp=%b covp=%b",
                       n_results, got.ok, got.state, got.enables, got.ocp_latches,
                       got.ovp_latch, got.ocp_clear, got.ovp_clear);
            end
          end
        end
        n_results++;
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        out_stall <= 1'b1;
      end else if (long_hold) begin
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        rcv_gap = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off partway through, so the block backs up.
  initial begin
    wait (n_taken >= 400);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int i;
    int c;
    for (i = 0; i < NCH; i++) mode_q[i] = MODE_UNINIT;
    ocp_lat = '0;
    ovp_lat = 1'b0;
    out_en = '0;

    // Directed part: out-of-range channels, unused codes, latch and clear rules.
    queue_command(FN_QUERY, 0, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_INIT, int'(CHAN_MAX), 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_START, NCH, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_INIT, 0, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_START, 0, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_INIT, 1, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_START, 1, 1'b0, 1'b0, NO_CH, 5'b00010);
    queue_command(FN_CLR_OCP, 1, 1'b0, 1'b0, 5'b00010, NO_CH);
    queue_command(FN_CLR_OCP, 1, 1'b0, 1'b0, NO_CH, 5'b00010);
    queue_command(FN_CLR_OCP, 1, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_OCP_EVT, 0, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_CLR_OCP, 6, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_OCP_EVT, NCH, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_STOP, 2, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_INIT, 4, 1'b1, 1'b0, ALL_CH, NO_CH);
    queue_command(FN_CLR_OVP, 0, 1'b1, 1'b0, NO_CH, NO_CH);
    queue_command(FN_CLR_OVP, 0, 1'b0, 1'b1, NO_CH, NO_CH);
    queue_command(FN_CLR_OCP, 0, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_CLR_OVP, 0, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_CLR_ALL, 0, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_START, 4, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_STOP_ALL, 3, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_OVP_EVT, 2, 1'b0, 1'b0, NO_CH, NO_CH);
    queue_command(FN_CLR_ALL, 0, 1'b0, 1'b0, NO_CH, ALL_CH);
    queue_command(FN_FIRST_UNUSED, int'(CHAN_MAX), 1'b1, 1'b1, ALL_CH, ALL_CH);
    queue_command(FN_LAST_UNUSED, 0, 1'b1, 1'b1, ALL_CH, ALL_CH);
    queue_command(FN_QUERY, int'(CHAN_MAX), 1'b1, 1'b1, ALL_CH, ALL_CH);

    // Random part: clean init and start pairs mixed with random commands.
    while (n_total < RANDOM_ITEMS + 27) begin
      if ($urandom_range(0, 3) == 0) begin
        c = $urandom_range(0, NCH - 1);
        queue_command(FN_INIT, c, 1'b0, 1'b0, NO_CH, NO_CH);
        queue_command(FN_START, c, 1'b0, 1'b0, NO_CH, NO_CH);
      end else begin
        queue_random_command();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_total) @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && status_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
